### rtl/core/sjpe_pkg.sv
// Shared types and constants for the servo jog packet encoder.
// No dependencies; imported by every module of the block but sjpe_checker.
package sjpe_pkg;

	// Packet framing
	localparam logic [7:0] HDR_BYTE = 8'hFF;
	localparam logic [7:0] PKT_SIZE = 8'h0C;
	localparam logic [7:0] CMD_SJOG = 8'h06;
	localparam logic [7:0] CHK_MASK = 8'hFE;
	localparam logic [7:0] ID_RESET = 8'hFE;

	// Range limits
	localparam logic [11:0] MAX_TIME_MS = 12'd2856;
	localparam logic [10:0] GOAL_MOST_NEG = 11'h400;

	// Play time = floor(ms * 5 / 56), via reciprocal multiply
	localparam int PLAY_N_W = 15;
	localparam logic [PLAY_N_W-1:0] PLAY_RECIP = 15'd18725;
	localparam int PLAY_SHIFT = 20;
	localparam int PLAY_PROD_W = 2 * PLAY_N_W;

	// Set value bits
	localparam logic [7:0] SET_STOP = 8'h01;
	localparam logic [7:0] SET_SPEED = 8'h02;
	localparam logic [7:0] LED_GREEN = 8'h04;
	localparam logic [7:0] LED_BLUE = 8'h08;
	localparam logic [7:0] LED_RED = 8'h10;

	localparam logic [1:0] LED_SEL_NONE = 2'd0;
	localparam logic [1:0] LED_SEL_GREEN = 2'd1;
	localparam logic [1:0] LED_SEL_BLUE = 2'd2;
	localparam logic [1:0] LED_SEL_RED = 2'd3;

	localparam logic MODE_POS = 1'b0;

	// Byte positions within the packet
	localparam logic [3:0] BI_HDR0 = 4'd0;
	localparam logic [3:0] BI_HDR1 = 4'd1;
	localparam logic [3:0] BI_SIZE = 4'd2;
	localparam logic [3:0] BI_ID0 = 4'd3;
	localparam logic [3:0] BI_CMD = 4'd4;
	localparam logic [3:0] BI_CHK1 = 4'd5;
	localparam logic [3:0] BI_CHK2 = 4'd6;
	localparam logic [3:0] BI_PLAY = 4'd7;
	localparam logic [3:0] BI_GLSB = 4'd8;
	localparam logic [3:0] BI_GMSB = 4'd9;
	localparam logic [3:0] BI_SET = 4'd10;
	localparam logic [3:0] BI_ID1 = 4'd11;

	// Request queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified request as it waits for the serializer
	typedef struct packed {
		logic       rejected;
		logic [7:0] play;
		logic [7:0] goal_lsb;
		logic [7:0] goal_msb;
		logic [7:0] setval;
		logic [7:0] sum;
	} job_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/core/servo_jog_packet_encoder_unit.sv
// An accepted request is registered in the queue; the back end then loads its bytes
// into the output register, one packet byte per cycle unless the receiver stalls.
// Packets are twelve bytes, rejections one beat; a two-entry queue holds requests.
// Reset (arst_n low, asynchronous): queue empties, output beat drops, servo_id = 0xFE.
// Top level of the servo jog packet encoder; depends on sjpe_pkg,
// sjpe_front, sjpe_queue and sjpe_back.
module servo_jog_packet_encoder_unit import sjpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// servo id register
	input  logic        id_we,
	input  logic [7:0]  id_wdata,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        mode,
	input  logic [10:0] goal,
	input  logic [11:0] play_time_ms,
	input  logic [1:0]  led_choice,
	// packet byte channel
	output logic        pkt_valid,
	input  logic        pkt_stall,
	output logic [7:0]  packet_byte,
	output logic        last_byte,
	output logic        rejected
);

	logic [7:0] servo_id_q;
	q_stat_t    q_stat;
	job_t       new_job;
	job_t       head_job;
	logic       push;
	logic       pop;

	// Target id; the user must write it only while no packet is in flight (not enforced
	// by the block), so the serializer reads it live for both id bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_id_q <= ID_RESET;
		end else if (id_we) begin
			servo_id_q <= id_wdata;
		end
	end

	// Front: check ranges, scale play time, build goal word and set value,
	// fold the data bytes into the running XOR. Stall only when the queue is full.
	sjpe_front u_front (
		.req_valid    (req_valid),
		.mode         (mode),
		.goal         (goal),
		.play_time_ms (play_time_ms),
		.led_choice   (led_choice),
		.q_stat       (q_stat),
		.req_stall    (req_stall),
		.push         (push),
		.job          (new_job)
	);

	// Queue: holds up to two classified requests while the back end drains.
	sjpe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (new_job),
		.pop    (pop),
		.head   (head_job),
		.stat   (q_stat)
	);

	// Back: emit header, id, command, checksums and data one beat at a time;
	// advance on each free output slot, drop the queue head after its last beat.
	sjpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.servo_id    (servo_id_q),
		.head        (head_job),
		.q_stat      (q_stat),
		.pop         (pop),
		.pkt_stall   (pkt_stall),
		.pkt_valid   (pkt_valid),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.rejected    (rejected)
	);

endmodule

### rtl/core/sjpe_front.sv
// Front end: range-checks a request and precomputes the packet data bytes.
// Depends on sjpe_pkg.
module sjpe_front import sjpe_pkg::*; (
	input  logic        req_valid,
	input  logic        mode,
	input  logic [10:0] goal,
	input  logic [11:0] play_time_ms,
	input  logic [1:0]  led_choice,
	input  q_stat_t     q_stat,
	output logic        req_stall,
	output logic        push,
	output job_t        job
);

	logic [PLAY_N_W-1:0]    time_x5;
	logic [PLAY_PROD_W-1:0] prod;
	logic [7:0]             led_bit;
	logic                   neg;
	logic [9:0]             mag;
	logic                   bad;

	assign req_stall = q_stat.full;
	assign push = req_valid && !q_stat.full;

	// ms * 5 / 56 through the reciprocal; exact for every 12-bit time
	assign time_x5 = {1'b0, play_time_ms, 2'b00} + {3'b000, play_time_ms};
	assign prod = PLAY_PROD_W'(time_x5) * PLAY_PROD_W'(PLAY_RECIP);

	assign neg = goal[10];
	assign mag = neg ? 10'(~goal + 11'd1) : goal[9:0];

	always_comb begin
		case (led_choice)
			LED_SEL_NONE:  led_bit = 8'h00;
			LED_SEL_GREEN: led_bit = LED_GREEN;
			LED_SEL_BLUE:  led_bit = LED_BLUE;
			LED_SEL_RED:   led_bit = LED_RED;
			default:       led_bit = 8'h00;
		endcase
	end

	always_comb begin
		bad = play_time_ms > MAX_TIME_MS;
		job.play = prod[PLAY_SHIFT +: 8];
		if (mode == MODE_POS) begin
			bad = bad || neg;
			job.goal_lsb = goal[7:0];
			job.goal_msb = {6'b0, goal[9:8]};
			job.setval = led_bit;
		end else begin
			bad = bad || (goal == GOAL_MOST_NEG);
			job.goal_lsb = mag[7:0];
			// direction flag is bit 14 of the goal word
			job.goal_msb = {1'b0, neg, 4'b0, mag[9:8]};
			job.setval = SET_SPEED | led_bit | ((goal == 11'd0) ? SET_STOP : 8'h00);
		end
		job.rejected = bad;
		// the id appears twice in the covered bytes and cancels out
		job.sum = PKT_SIZE ^ CMD_SJOG ^ job.play ^ job.goal_lsb ^ job.goal_msb ^ job.setval;
	end

endmodule

### rtl/core/sjpe_queue.sv
// Two-entry queue of classified requests between front and back end.
// Depends on sjpe_pkg.
module sjpe_queue import sjpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wr_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full = cnt_q == QCNT_W'(QDEPTH);
	assign stat.empty = cnt_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/sjpe_back.sv
// Back end: walks the queue head through the twelve packet bytes into an
// output register. Depends on sjpe_pkg.
module sjpe_back import sjpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] servo_id,
	input  job_t       head,
	input  q_stat_t    q_stat,
	output logic       pop,
	input  logic       pkt_stall,
	output logic       pkt_valid,
	output logic [7:0] packet_byte,
	output logic       last_byte,
	output logic       rejected
);

	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       rej_q;
	logic       load;
	logic       end_of_job;
	logic [7:0] nxt_byte;

	assign load = !q_stat.empty && (!valid_q || !pkt_stall);
	assign end_of_job = head.rejected || (idx_q == BI_ID1);
	assign pop = load && end_of_job;

	always_comb begin
		case (idx_q)
			BI_HDR0: nxt_byte = HDR_BYTE;
			BI_HDR1: nxt_byte = HDR_BYTE;
			BI_SIZE: nxt_byte = PKT_SIZE;
			BI_ID0:  nxt_byte = servo_id;
			BI_CMD:  nxt_byte = CMD_SJOG;
			BI_CHK1: nxt_byte = head.sum & CHK_MASK;
			BI_CHK2: nxt_byte = ~head.sum & CHK_MASK;
			BI_PLAY: nxt_byte = head.play;
			BI_GLSB: nxt_byte = head.goal_lsb;
			BI_GMSB: nxt_byte = head.goal_msb;
			BI_SET:  nxt_byte = head.setval;
			BI_ID1:  nxt_byte = servo_id;
			default: nxt_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= BI_HDR0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= end_of_job ? BI_HDR0 : idx_q + 4'd1;
		end else if (!pkt_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.rejected ? 8'h00 : nxt_byte;
			last_q <= end_of_job;
			rej_q <= head.rejected;
		end
	end

	assign pkt_valid = valid_q;
	assign packet_byte = byte_q;
	assign last_byte = last_q;
	assign rejected = rej_q;

endmodule

### rtl/core/sjpe_checker.sv
// Port-level checks for the servo jog packet encoder, bound to the top level.
// Depends only on the top-level ports.
module sjpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pkt_valid,
	input logic        pkt_stall,
	input logic [7:0]  packet_byte,
	input logic        last_byte,
	input logic        rejected
);

	a_rej_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && rejected |-> last_byte)
		else $error("reject beat without last_byte");

	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && rejected |-> packet_byte == 8'h00)
		else $error("reject beat carries nonzero byte");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_stall |=> pkt_valid)
		else $error("output beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_stall |=> $stable(packet_byte) && $stable(last_byte)
			&& $stable(rejected))
		else $error("output beat changed while stalled");

endmodule

bind servo_jog_packet_encoder_unit sjpe_checker u_sjpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pkt_valid   (pkt_valid),
	.pkt_stall   (pkt_stall),
	.packet_byte (packet_byte),
	.last_byte   (last_byte),
	.rejected    (rejected)
);

### bench/sjpe_jog_checker.sv
// Checker for the servo jog packet encoder: watches both channels and the id port,
// predicts every packet byte and compares it with what the block sends.
// Depends on sjpe_pkg.
module sjpe_jog_checker import sjpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        id_we,
	input  logic [7:0]  id_wdata,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        mode,
	input  logic [10:0] goal,
	input  logic [11:0] play_time_ms,
	input  logic [1:0]  led_choice,
	input  logic        pkt_valid,
	input  logic        pkt_stall,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	input  logic        rejected,
	output int          fail_count,
	output int          expected_left
);

	localparam logic [15:0] SPEED_REVERSE = 16'h4000;
	localparam int          MAX_SPEED     = 1023;
	localparam int          PACKET_BYTES  = 12;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       rej;
	} pkt_beat_t;

	pkt_beat_t  pending_bytes[$];
	logic [7:0] servo_id_q;
	int         beats_seen;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch at output byte %0d: %s", $time, beats_seen, what);
		fail_count++;
	endtask

	function automatic void push_beat(input logic [7:0] data, input logic last,
			input logic rej);
		pkt_beat_t b;
		b.data = data;
		b.last = last;
		b.rej  = rej;
		pending_bytes.push_back(b);
	endfunction

	// Build the expected bytes of one jog request
	function automatic void queue_jog_packet(input logic m, input logic [10:0] g_raw,
			input logic [11:0] ms, input logic [1:0] led);
		int          g;
		int          mag;
		logic [7:0]  led_bit;
		logic [7:0]  set_v;
		logic [7:0]  play_b;
		logic [7:0]  sum;
		logic [15:0] goal_w;
		logic [7:0]  bytes_out[PACKET_BYTES];
		g = $signed(g_raw);
		case (led)
			LED_SEL_GREEN: led_bit = LED_GREEN;
			LED_SEL_BLUE:  led_bit = LED_BLUE;
			LED_SEL_RED:   led_bit = LED_RED;
			default:       led_bit = 8'h00;
		endcase
		mag = (g < 0) ? -g : g;
		if (ms > MAX_TIME_MS || (m == MODE_POS && g < 0) ||
				(m != MODE_POS && mag > MAX_SPEED)) begin
			push_beat(8'h00, 1'b1, 1'b1);
			return;
		end
		if (m == MODE_POS) begin
			goal_w = g[15:0];
			set_v  = led_bit;
		end else begin
			goal_w = (g < 0) ? (mag[15:0] | SPEED_REVERSE) : mag[15:0];
			set_v  = SET_SPEED | led_bit | ((g == 0) ? SET_STOP : 8'h00);
		end
		play_b = 8'((int'(ms) * 5) / 56);
		sum = PKT_SIZE ^ servo_id_q ^ CMD_SJOG ^ play_b ^ goal_w[7:0] ^ goal_w[15:8] ^
			set_v ^ servo_id_q;
		bytes_out[BI_HDR0] = HDR_BYTE;
		bytes_out[BI_HDR1] = HDR_BYTE;
		bytes_out[BI_SIZE] = PKT_SIZE;
		bytes_out[BI_ID0]  = servo_id_q;
		bytes_out[BI_CMD]  = CMD_SJOG;
		bytes_out[BI_CHK1] = sum & CHK_MASK;
		bytes_out[BI_CHK2] = ~sum & CHK_MASK;
		bytes_out[BI_PLAY] = play_b;
		bytes_out[BI_GLSB] = goal_w[7:0];
		bytes_out[BI_GMSB] = goal_w[15:8];
		bytes_out[BI_SET]  = set_v;
		bytes_out[BI_ID1]  = servo_id_q;
		for (int i = 0; i < PACKET_BYTES; i++)
			push_beat(bytes_out[i], (i == PACKET_BYTES - 1), 1'b0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pkt_beat_t want;
		if (!arst_n) begin
			pending_bytes.delete();
			servo_id_q    = ID_RESET;
			fail_count    = 0;
			beats_seen    = 0;
			expected_left = 0;
		end else begin
			if (pkt_valid && !pkt_stall) begin
				if (pending_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h with nothing expected", packet_byte));
				end else begin
					want = pending_bytes.pop_front();
					if (packet_byte !== want.data)
						report_mismatch($sformatf("packet_byte %02h, want %02h",
							packet_byte, want.data));
					if (last_byte !== want.last)
						report_mismatch($sformatf("last_byte %b, want %b", last_byte, want.last));
					if (rejected !== want.rej)
						report_mismatch($sformatf("rejected %b, want %b", rejected, want.rej));
				end
				beats_seen++;
			end
			// a request at this edge still sees the old id
			if (req_valid && !req_stall)
				queue_jog_packet(mode, goal, play_time_ms, led_choice);
			if (id_we)
				servo_id_q = id_wdata;
			expected_left = pending_bytes.size();
		end
	end

endmodule

### bench/testbench.sv
// Top of the servo jog packet encoder bench: clock, reset, request and stall stimulus
// and the verdict. Depends on sjpe_pkg, servo_jog_packet_encoder_unit and sjpe_jog_checker.
module testbench;
	import sjpe_pkg::*;

	localparam logic MODE_SPEED  = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   HOLD_CYCLES = 80;
	localparam int   PHASE_ITEMS = 50;

	logic        clk;
	logic        arst_n;
	logic        id_we;
	logic [7:0]  id_wdata;
	logic        req_valid;
	logic        req_stall;
	logic        mode;
	logic [10:0] goal;
	logic [11:0] play_time_ms;
	logic [1:0]  led_choice;
	logic        pkt_valid;
	logic        pkt_stall;
	logic [7:0]  packet_byte;
	logic        last_byte;
	logic        rejected;

	int fail_count;
	int expected_left;
	int cycle_count;

	// Shared between the request driver and the stall driver
	bit steady;        // no idling on either side while set
	bit hold_off_req;  // ask the receiver for one long hold-off

	servo_jog_packet_encoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.id_we       (id_we),
		.id_wdata    (id_wdata),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.goal        (goal),
		.play_time_ms(play_time_ms),
		.led_choice  (led_choice),
		.pkt_valid   (pkt_valid),
		.pkt_stall   (pkt_stall),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.rejected    (rejected)
	);

	sjpe_jog_checker jog_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.id_we        (id_we),
		.id_wdata     (id_wdata),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.mode         (mode),
		.goal         (goal),
		.play_time_ms (play_time_ms),
		.led_choice   (led_choice),
		.pkt_valid    (pkt_valid),
		.pkt_stall    (pkt_stall),
		.packet_byte  (packet_byte),
		.last_byte    (last_byte),
		.rejected     (rejected),
		.fail_count   (fail_count),
		.expected_left(expected_left)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: end the run if the block hangs or drops bytes
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Receiver: random stalls, a stall-free stretch, and one long hold-off
	// during which the sender keeps offering so the queue backs up.
	initial begin
		pkt_stall <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pkt_stall <= 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				pkt_stall <= 1'b0;
			end else if (steady) begin
				pkt_stall <= 1'b0;
			end else begin
				pkt_stall <= ($urandom_range(99) < 23);
			end
		end
	end

	// Offer one request beat and hold it until the block takes it.
	// Returns in the step of the accepting edge with valid still high.
	task automatic send_jog(input logic m, input int g, input int t, input logic [1:0] led);
		if (!steady) begin
			while ($urandom_range(99) < 23) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid    <= 1'b1;
		mode         <= m;
		goal         <= g[10:0];
		play_time_ms <= t[11:0];
		led_choice   <= led;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Mostly well-formed requests with random content, extremes now and then,
	// and a share of raw bit patterns, about half of which are refused.
	task automatic send_random_jog();
		int   pick;
		int   g;
		int   t;
		logic m;
		pick = $urandom_range(99);
		m    = 1'($urandom_range(1));
		if (pick < 15) begin
			g = $urandom_range(2047);
			t = $urandom_range(4095);
		end else begin
			if (m == MODE_POS)
				g = $urandom_range(1023);
			else
				g = int'($urandom_range(2046)) - 1023;
			if (pick < 27) begin
				case ($urandom_range(2))
					0:       g = 0;
					1:       g = 1023;
					default: g = (m == MODE_POS) ? 1023 : -1023;
				endcase
			end
			t = (pick % 9 == 0) ? 2856 : $urandom_range(2856);
		end
		send_jog(m, g, t, 2'($urandom_range(3)));
	endtask

	// Drop valid, wait for every expected byte, then let the pipe go quiet
	task automatic settle();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_left != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_servo_id(input logic [7:0] v);
		id_we    <= 1'b1;
		id_wdata <= v;
		@(posedge clk);
		id_we    <= 1'b0;
	endtask

	initial begin
		arst_n       <= 1'b0;
		id_we        <= 1'b0;
		id_wdata     <= 8'h00;
		req_valid    <= 1'b0;
		mode         <= MODE_POS;
		goal         <= 11'h000;
		play_time_ms <= 12'h000;
		led_choice   <= LED_SEL_NONE;
		steady       = 1'b0;
		hold_off_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: range edges, both modes, every LED, every refusal, id at reset value
		send_jog(MODE_POS,   0,     0,    LED_SEL_NONE);
		send_jog(MODE_POS,   1023,  2856, LED_SEL_GREEN);
		send_jog(MODE_POS,   512,   11,   LED_SEL_BLUE);
		send_jog(MODE_POS,   255,   12,   LED_SEL_RED);
		send_jog(MODE_POS,   -1,    100,  LED_SEL_NONE);   // negative position
		send_jog(MODE_POS,   -1024, 100,  LED_SEL_GREEN);  // negative position
		send_jog(MODE_SPEED, 0,     56,   LED_SEL_BLUE);   // stop bit
		send_jog(MODE_SPEED, 0,     0,    LED_SEL_NONE);   // stop bit
		send_jog(MODE_SPEED, 1023,  2856, LED_SEL_RED);
		send_jog(MODE_SPEED, -1023, 2856, LED_SEL_GREEN);  // reverse flag
		send_jog(MODE_SPEED, -1,    1,    LED_SEL_RED);    // reverse flag
		send_jog(MODE_SPEED, 1,     55,   LED_SEL_NONE);
		send_jog(MODE_SPEED, -1024, 100,  LED_SEL_BLUE);   // speed beyond range
		send_jog(MODE_POS,   100,   2857, LED_SEL_NONE);   // time just over
		send_jog(MODE_POS,   100,   4095, LED_SEL_RED);    // time at field max
		send_jog(MODE_SPEED, -512,  4095, LED_SEL_GREEN);  // time over, speed mode
		send_jog(MODE_SPEED, 682,   2048, LED_SEL_BLUE);
		send_jog(MODE_POS,   1365,  1365, LED_SEL_GREEN);  // bit 10 set, refused
		settle();

		// Lowest id, with a long receiver hold-off at the start
		write_servo_id(8'd0);
		hold_off_req = 1'b1;
		repeat (PHASE_ITEMS) send_random_jog();
		settle();

		// Unchecked id 255, no idling on either side
		write_servo_id(8'd255);
		steady = 1'b1;
		repeat (PHASE_ITEMS) send_random_jog();
		steady = 1'b0;
		settle();

		write_servo_id(8'($urandom_range(253, 1)));
		repeat (PHASE_ITEMS) send_random_jog();
		settle();

		// Back to broadcast, written explicitly
		write_servo_id(ID_RESET);
		repeat (PHASE_ITEMS) send_random_jog();
		settle();
		repeat (20) @(posedge clk);

		if (fail_count == 0 && expected_left == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
